// File: sv/mrp_pkg.sv
// shared constants and types for the miller-rabin primality tester
package mrp_pkg;

    localparam int WIT_NUM = 3;
    localparam int WIT_W   = 6;

    typedef logic [WIT_W-1:0] t_wit;
    typedef logic [1:0]       t_wit_idx;

    localparam t_wit WITNESS [WIT_NUM] = '{t_wit'(2), t_wit'(7), t_wit'(61)};

    localparam t_wit_idx WIT_LAST = t_wit_idx'(WIT_NUM - 1);

endpackage

// File: sv/mrp_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
module mrp_mulmod #(
    parameter int NUM_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [NUM_BITS-1:0] i_x,
    input  logic [NUM_BITS-1:0] i_y,
    input  logic [NUM_BITS-1:0] i_n,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_res
);

    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_acc;
    logic [NUM_BITS-1:0] r_x;
    logic [NUM_BITS-1:0] r_ysh;
    logic [CW-1:0]       r_cnt;
    logic                r_run;
    logic                r_done;

    logic [NUM_BITS+1:0] n_sum;
    logic [NUM_BITS+1:0] n_n1;
    logic [NUM_BITS+1:0] n_n2;
    logic [NUM_BITS+1:0] n_red;

    // acc < n, so 2*acc + x < 3n: at most two subtractions of n
    always_comb begin
        n_n1  = {2'b00, i_n};
        n_n2  = {1'b0, i_n, 1'b0};
        n_sum = {1'b0, r_acc, 1'b0} + (r_ysh[NUM_BITS-1] ? {2'b00, r_x} : '0);
        if (n_sum >= n_n2) begin
            n_red = n_sum - n_n2;
        end else if (n_sum >= n_n1) begin
            n_red = n_sum - n_n1;
        end else begin
            n_red = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= CW'(NUM_BITS);
                r_acc <= '0;
                r_x   <= i_x;
                r_ysh <= i_y;
            end else if (r_run) begin
                r_acc <= n_red[NUM_BITS-1:0];
                r_ysh <= {r_ysh[NUM_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

// File: sv/miller_rabin_primality_32.sv
// deterministic miller-rabin primality tester, witnesses 2, 7 and 61
//
//  channel  | signals                     | direction | beat
//  ---------+-----------------------------+-----------+---------------------------
//  command  | start, busy, i_candidate    | in        | start high while busy low
//  result   | o_done, o_is_prime          | out       | o_done high for one cycle
//
// one item at a time; each modular multiply is issued to and handed back from the shared
// bit-serial multiplier, at most 3*(2*NUM_BITS) multiplies for a prime;
// even input and input below 2 are settled in the check state without a multiply
// busy is high from the accepting edge until the result cycle, where it is low again
// synchronous active-low reset returns the sequencer to idle
// the receiver cannot stall: the result is shown for exactly one cycle
module miller_rabin_primality_32 #(
    parameter int NUM_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_candidate,
    output logic        o_done,
    output logic        o_is_prime
);

    localparam int RW = $clog2(NUM_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SPLIT,
        S_RED,
        S_EXP,
        S_MULX,
        S_MULA,
        S_CHK1,
        S_SQ,
        S_SQW,
        S_NEXT
    } t_state;

    t_state               r_state;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_prime;
    logic [NUM_BITS-1:0]  r_n;
    logic [NUM_BITS-1:0]  r_dodd;
    logic [NUM_BITS-1:0]  r_e;
    logic [NUM_BITS-1:0]  r_x;
    logic [NUM_BITS-1:0]  r_a;
    logic [NUM_BITS-1:0]  r_opa;
    logic [NUM_BITS-1:0]  r_opb;
    logic                 r_mgo;
    logic [RW-1:0]        r_r;
    logic [RW-1:0]        r_k;
    mrp_pkg::t_wit_idx    r_wit;

    logic [NUM_BITS-1:0]  n_nm1;
    logic [NUM_BITS-1:0]  n_e_sh;
    logic                 mul_done;
    logic [NUM_BITS-1:0]  mul_res;

    assign n_nm1  = r_n - NUM_BITS'(1);
    assign n_e_sh = {1'b0, r_e[NUM_BITS-1:1]};

    mrp_mulmod #(
        .NUM_BITS (NUM_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_mgo),
        .i_x     (r_opa),
        .i_y     (r_opb),
        .i_n     (r_n),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_mgo   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_mgo  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_n     <= i_candidate[NUM_BITS-1:0];
                        r_busy  <= 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_n < NUM_BITS'(2) || (r_n != NUM_BITS'(2) && !r_n[0])) begin
                        r_prime <= 1'b0;
                        r_done  <= 1'b1;
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (r_n == NUM_BITS'(2)) begin
                        r_prime <= 1'b1;
                        r_done  <= 1'b1;
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_dodd  <= n_nm1;
                        r_r     <= '0;
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (!r_dodd[0]) begin
                        r_dodd <= {1'b0, r_dodd[NUM_BITS-1:1]};
                        r_r    <= r_r + RW'(1);
                    end else begin
                        r_wit   <= '0;
                        r_a     <= NUM_BITS'(mrp_pkg::WITNESS[0]);
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    // base mod n by repeated subtraction, small bases only
                    if (r_a >= r_n) begin
                        r_a <= r_a - r_n;
                    end else if (r_a == '0) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_x     <= NUM_BITS'(1);
                        r_e     <= r_dodd;
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_e == '0) begin
                        r_state <= S_CHK1;
                    end else if (r_e[0]) begin
                        r_opa   <= r_x;
                        r_opb   <= r_a;
                        r_mgo   <= 1'b1;
                        r_state <= S_MULX;
                    end else begin
                        r_e     <= n_e_sh;
                        r_opa   <= r_a;
                        r_opb   <= r_a;
                        r_mgo   <= 1'b1;
                        r_state <= S_MULA;
                    end
                end
                S_MULX: begin
                    if (mul_done) begin
                        r_x <= mul_res;
                        r_e <= n_e_sh;
                        if (n_e_sh == '0) begin
                            r_state <= S_CHK1;
                        end else begin
                            r_opa   <= r_a;
                            r_opb   <= r_a;
                            r_mgo   <= 1'b1;
                            r_state <= S_MULA;
                        end
                    end
                end
                S_MULA: begin
                    if (mul_done) begin
                        r_a     <= mul_res;
                        r_state <= S_EXP;
                    end
                end
                S_CHK1: begin
                    if (r_x == NUM_BITS'(1) || r_x == n_nm1) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_k     <= RW'(1);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_k >= r_r) begin
                        r_prime <= 1'b0;
                        r_done  <= 1'b1;
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_opa   <= r_x;
                        r_opb   <= r_x;
                        r_mgo   <= 1'b1;
                        r_state <= S_SQW;
                    end
                end
                S_SQW: begin
                    if (mul_done) begin
                        r_x <= mul_res;
                        r_k <= r_k + RW'(1);
                        if (mul_res == n_nm1) begin
                            r_state <= S_NEXT;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_NEXT: begin
                    if (r_wit == mrp_pkg::WIT_LAST) begin
                        r_prime <= 1'b1;
                        r_done  <= 1'b1;
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_wit   <= r_wit + mrp_pkg::t_wit_idx'(1);
                        r_a     <= NUM_BITS'(mrp_pkg::WITNESS[r_wit + mrp_pkg::t_wit_idx'(1)]);
                        r_state <= S_RED;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy       = r_busy;
    assign o_done     = r_done;
    assign o_is_prime = r_prime;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("more than one result for one command");

    a_idle_matches_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_state != S_IDLE)
        else $error("sequencer idle while busy");

endmodule
